>>> hw/rtl/range_filtered_top3_mean_core_defines.svh
// ----------------------------------------------------------------------------
// range_filtered_top3_mean_core_defines.svh
// Assertion macros shared by the range-filtered top-three mean core.
// ----------------------------------------------------------------------------
`ifndef RANGE_FILTERED_TOP3_MEAN_CORE_DEFINES_SVH
`define RANGE_FILTERED_TOP3_MEAN_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RF3M_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rf3m assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RF3M_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rf3m assertion failed");

`endif

>>> hw/rtl/rf3m_pkg.sv
// ----------------------------------------------------------------------------
// rf3m_pkg
// Types and constants for the range-filtered top-three mean core.
// ----------------------------------------------------------------------------
package rf3m_pkg;

    localparam int W       = 20;  // Q15.4 weight width
    localparam int SUM_W   = W + 2;  // sum of up to three weights
    localparam int MAG_W   = W + 1;  // magnitude of that sum
    localparam int USED_W  = 2;
    localparam int RECIP_W = 20;
    localparam int RECIP_SHIFT = 21;
    localparam int PROD_W  = MAG_W + RECIP_W;

    // ceil(2^21 / 3): exact floor division by 3 for magnitudes below 2^21
    localparam logic [RECIP_W-1:0] RECIP3 = 20'd699051;

    typedef logic signed [W-1:0] weight_t;

    localparam weight_t LOWER_RESET = 20'sd0;
    localparam weight_t UPPER_RESET = 20'sd16000;  // 1000.0

    typedef enum logic [0:0] {
        REG_LOWER_LIMIT = 1'b0,
        REG_UPPER_LIMIT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic         we;
        cfg_reg_t     index;
        logic [W-1:0] data;
    } cfg_wr_t;

endpackage

>>> hw/rtl/rf3m_sample_if.sv
// ----------------------------------------------------------------------------
// rf3m_sample_if
// Valid/ready channel carrying one weight sample and its last-of-batch mark.
// ----------------------------------------------------------------------------
interface rf3m_sample_if;
    import rf3m_pkg::*;

    logic    valid;
    logic    ready;
    weight_t weight;
    logic    last_sample;

    modport source (output valid, output weight, output last_sample, input ready);
    modport sink   (input valid, input weight, input last_sample, output ready);
endinterface

>>> hw/rtl/rf3m_result_if.sv
// ----------------------------------------------------------------------------
// rf3m_result_if
// Valid/ready channel carrying one batch result: mean and sample count.
// ----------------------------------------------------------------------------
interface rf3m_result_if;
    import rf3m_pkg::*;

    logic              valid;
    logic              ready;
    weight_t           top_mean;
    logic [USED_W-1:0] used_count;

    modport source (output valid, output top_mean, output used_count, input ready);
    modport sink   (input valid, input top_mean, input used_count, output ready);
endinterface

>>> hw/rtl/rf3m_rank.sv
// ----------------------------------------------------------------------------
// rf3m_rank
// Input register, limit registers and the sorted top-N insert. On the last
// word of a batch the updated list is handed off as a snapshot and cleared.
// ----------------------------------------------------------------------------
module rf3m_rank #(
    parameter int TOP_COUNT = 3,
    parameter int CNT_W     = $clog2(TOP_COUNT + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    rf3m_sample_if.sink         sample,
    input  rf3m_pkg::cfg_wr_t   cfg,
    output rf3m_pkg::weight_t   snap_values [TOP_COUNT],
    output logic [CNT_W-1:0]    snap_count,
    output logic                snap_valid,
    input  logic                snap_ready
);
    import rf3m_pkg::*;

    weight_t lower_reg;
    weight_t upper_reg;

    logic    in_valid_reg;
    logic    in_last_reg;
    logic    in_ok_reg;
    weight_t in_weight_reg;

    weight_t          best_reg   [TOP_COUNT];
    weight_t          best_next  [TOP_COUNT];
    weight_t          best_ins   [TOP_COUNT];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] count_ins;
    logic [TOP_COUNT-1:0] keep;

    weight_t          snap_reg [TOP_COUNT];
    logic [CNT_W-1:0] snap_count_reg;
    logic             snap_valid_reg;

    logic snap_free;
    logic in_adv;
    logic accept;
    logic in_range;

    assign snap_free    = !snap_valid_reg || snap_ready;
    // non-last words only touch local state, so they never wait on downstream
    assign in_adv       = in_valid_reg && (!in_last_reg || snap_free);
    assign sample.ready = !in_valid_reg || in_adv;
    assign accept       = sample.valid && sample.ready;
    assign in_range     = (sample.weight >= lower_reg) && (sample.weight <= upper_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg <= LOWER_RESET;
            upper_reg <= UPPER_RESET;
        end
        else if (cfg.we)
        begin
            unique case (cfg.index)
                REG_LOWER_LIMIT: lower_reg <= weight_t'(cfg.data);
                REG_UPPER_LIMIT: upper_reg <= weight_t'(cfg.data);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (in_adv)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_weight_reg <= sample.weight;
            in_last_reg   <= sample.last_sample;
            in_ok_reg     <= in_range;
        end
    end

    // Kept slots are sorted descending, so keep[] is a prefix; an equal value
    // stays ahead of the new one.
    always_comb
    begin
        for (int i = 0; i < TOP_COUNT; i++)
        begin
            keep[i] = (CNT_W'(i) < count_reg) && (best_reg[i] >= in_weight_reg);
        end
        best_ins[0] = keep[0] ? best_reg[0] : in_weight_reg;
        for (int i = 1; i < TOP_COUNT; i++)
        begin
            if (keep[i])
                best_ins[i] = best_reg[i];
            else if (keep[i-1])
                best_ins[i] = in_weight_reg;
            else
                best_ins[i] = best_reg[i-1];
        end
        count_ins = (count_reg == CNT_W'(TOP_COUNT)) ? count_reg : count_reg + CNT_W'(1);

        best_next  = best_reg;
        count_next = count_reg;
        if (in_adv && in_ok_reg)
        begin
            best_next  = best_ins;
            count_next = count_ins;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOP_COUNT; i++)
            begin
                best_reg[i] <= '0;
            end
            count_reg <= '0;
        end
        else if (in_adv && in_last_reg)
        begin
            for (int i = 0; i < TOP_COUNT; i++)
            begin
                best_reg[i] <= '0;
            end
            count_reg <= '0;
        end
        else
        begin
            best_reg  <= best_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (in_adv && in_last_reg)
        begin
            snap_valid_reg <= 1'b1;
        end
        else if (snap_ready)
        begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_adv && in_last_reg)
        begin
            snap_reg       <= best_next;
            snap_count_reg <= count_next;
        end
    end

    assign snap_values = snap_reg;
    assign snap_count  = snap_count_reg;
    assign snap_valid  = snap_valid_reg;

endmodule

>>> hw/rtl/rf3m_mean.sv
// ----------------------------------------------------------------------------
// rf3m_mean
// Sums the kept samples, then divides by the count (truncating toward zero)
// into the output register.
// ----------------------------------------------------------------------------
module rf3m_mean #(
    parameter int TOP_COUNT = 3,
    parameter int CNT_W     = $clog2(TOP_COUNT + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rf3m_pkg::weight_t   snap_values [TOP_COUNT],
    input  logic [CNT_W-1:0]    snap_count,
    input  logic                snap_valid,
    output logic                snap_ready,
    rf3m_result_if.source       result
);
    import rf3m_pkg::*;

    logic signed [SUM_W-1:0] sum;
    logic [MAG_W-1:0]        mag;

    logic              sum_valid_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic              neg_reg;
    logic [USED_W-1:0] n_reg;

    logic [PROD_W-1:0] prod;
    logic [MAG_W-1:0]  q3;
    logic [MAG_W-1:0]  quot;
    logic [MAG_W-1:0]  quot_signed;

    logic              out_valid_reg;
    weight_t           mean_reg;
    logic [USED_W-1:0] used_reg;

    logic out_free;
    logic sum_free;

    assign out_free   = !out_valid_reg || result.ready;
    assign sum_free   = !sum_valid_reg || out_free;
    assign snap_ready = sum_free;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < TOP_COUNT; i++)
        begin
            if (CNT_W'(i) < snap_count)
                sum = sum + SUM_W'(snap_values[i]);
        end
        mag = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (sum_free)
        begin
            sum_valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_free && snap_valid)
        begin
            mag_reg <= mag;
            neg_reg <= sum[SUM_W-1];
            n_reg   <= USED_W'(snap_count);
        end
    end

    // Divide the magnitude, then restore the sign: truncation toward zero.
    always_comb
    begin
        prod = PROD_W'(mag_reg) * PROD_W'(RECIP3);
        q3   = MAG_W'(prod >> RECIP_SHIFT);
        unique case (n_reg)
            2'd0: quot = '0;
            2'd1: quot = mag_reg;
            2'd2: quot = mag_reg >> 1;
            2'd3: quot = q3;
        endcase
        quot_signed = neg_reg ? -quot : quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && sum_valid_reg)
        begin
            mean_reg <= weight_t'(quot_signed[W-1:0]);
            used_reg <= n_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.top_mean   = mean_reg;
    assign result.used_count = used_reg;

endmodule

>>> hw/rtl/range_filtered_top3_mean_core.sv
// ----------------------------------------------------------------------------
// range_filtered_top3_mean_core
// Keeps the largest in-range load-cell samples of a batch and reports their
// mean and count at the end of the batch.
// ----------------------------------------------------------------------------
// Usage:
//   sample: one signed Q15.4 weight per word, last_sample marks batch end.
//   result: one word per batch, the truncated mean of up to TOP_COUNT largest
//           samples within [lower_limit, upper_limit], and how many were used.
//   cfg:    write-only limits (index 0 lower, index 1 upper), written while idle.
// Throughput: one sample word per cycle unless a last word stalls; the top-N
//   insert is a single compare and shift per word against registered state.
// Path: the last word of a batch passes the input register, snapshot, sum and
//   divide/output registers before its result word is valid.
// Reset: limits return to 0.0 and 1000.0, the kept list and count clear, all
//   pipeline stages empty.
// Stall: while result is held, non-last words keep flowing; a last word waits
//   in the input register only once the snapshot and sum stages are full.
// ----------------------------------------------------------------------------
`include "range_filtered_top3_mean_core_defines.svh"

module range_filtered_top3_mean_core #(
    parameter int TOP_COUNT = 3
) (
    input  logic                    clk,
    input  logic                    rst_n,
    rf3m_sample_if.sink             sample,
    rf3m_result_if.source           result,
    input  logic                    cfg_we,
    input  logic [0:0]              cfg_index,
    input  logic [rf3m_pkg::W-1:0]  cfg_data
);
    import rf3m_pkg::*;

    localparam int CNT_W = $clog2(TOP_COUNT + 1);

    cfg_wr_t          cfg;
    weight_t          snap_values [TOP_COUNT];
    logic [CNT_W-1:0] snap_count;
    logic             snap_valid;
    logic             snap_ready;
    logic             snap_sorted;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_reg_t'(cfg_index);
    assign cfg.data  = cfg_data;

    rf3m_rank #(
        .TOP_COUNT (TOP_COUNT),
        .CNT_W     (CNT_W)
    ) u_rank (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample),
        .cfg         (cfg),
        .snap_values (snap_values),
        .snap_count  (snap_count),
        .snap_valid  (snap_valid),
        .snap_ready  (snap_ready)
    );

    rf3m_mean #(
        .TOP_COUNT (TOP_COUNT),
        .CNT_W     (CNT_W)
    ) u_mean (
        .clk         (clk),
        .rst_n       (rst_n),
        .snap_values (snap_values),
        .snap_count  (snap_count),
        .snap_valid  (snap_valid),
        .snap_ready  (snap_ready),
        .result      (result)
    );

    // used slots of a snapshot must be in descending order
    always_comb
    begin
        snap_sorted = 1'b1;
        for (int i = 1; i < TOP_COUNT; i++)
        begin
            if ((CNT_W'(i) < snap_count) && (snap_values[i] > snap_values[i-1]))
                snap_sorted = 1'b0;
        end
    end

    `RF3M_ASSERT_IMPLIES(a_snap_sorted, clk, rst_n, snap_valid, snap_sorted)
    `RF3M_ASSERT_IMPLIES(a_count_range, clk, rst_n, snap_valid, snap_count <= CNT_W'(TOP_COUNT))
    `RF3M_ASSERT_IMPLIES(a_used_range, clk, rst_n, result.valid, result.used_count <= USED_W'(TOP_COUNT))
    `RF3M_ASSERT_IMPLIES(a_empty_zero, clk, rst_n, result.valid && (result.used_count == '0), result.top_mean == '0)

endmodule
